[rtl/core/assert_macros.svh]
// Assertion macros used by the ledger back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge outside reset.
`define PSWL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PSWL_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PSWL_ASSERT(lbl, clk, rstn, prop, msg)
`define PSWL_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

[rtl/core/pswl_pkg.sv]
// Types and constants of the per-sender event window ledger.
package pswl_pkg;

  localparam int unsigned NUM_SENDERS       = 256;
  localparam int unsigned EVENTS_PER_SENDER = 16;
  localparam int unsigned SENDER_W = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int unsigned SLOT_W   = (EVENTS_PER_SENDER > 1) ? $clog2(EVENTS_PER_SENDER) : 1;
  localparam int unsigned CNT_W    = $clog2(EVENTS_PER_SENDER + 1);
  localparam int unsigned EV_DEPTH = NUM_SENDERS << SLOT_W;
  localparam int unsigned EV_AW    = SENDER_W + SLOT_W;

  // Command queue between front and back (depth is a power of two)
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] WINDOW_RESET = 32'd60000;
  localparam logic [31:0] RETRY_RESET  = 32'd2000;
  localparam logic [3:0]  KEY4_MASK    = 4'h f;

  // Register indexes
  localparam logic REG_WINDOW = 1'b0;
  localparam logic REG_RETRY  = 1'b1;

  // Commands and event kinds
  localparam logic       CMD_OBSERVE = 1'b0;
  localparam logic       CMD_QUERY   = 1'b1;
  localparam logic [7:0] KIND_REQ    = 8'd0;
  localparam logic [7:0] KIND_CLR    = 8'd1;

  typedef struct packed {
    logic        command;
    logic [47:0] timestamp_ms;
    logic [7:0]  sender;
    logic [7:0]  kind;
    logic [7:0]  dedup_key;
    logic [15:0] airtime;
  } pswl_in_t;

  typedef struct packed {
    logic [4:0]  apparent_count;
    logic [19:0] total_airtime;
    logic [4:0]  request_count;
    logic [4:0]  clear_count;
  } pswl_out_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic        command;
    logic        out_of_range;
    logic [47:0] now;
    logic [47:0] cutoff;
    logic [48:0] retry_lo;
    logic [7:0]  sender;
    logic [7:0]  kind;
    logic [7:0]  dedup_key;
    logic [15:0] airtime;
  } pswl_cmd_t;

  // One stored event
  typedef struct packed {
    logic [47:0] time_ms;
    logic [7:0]  kind;
    logic [7:0]  key;
    logic [15:0] air;
  } pswl_ev_t;

  localparam int unsigned EV_W = $bits(pswl_ev_t);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CNT    = 5'b00010,
    S_SCAN   = 5'b00100,
    S_EVICT  = 5'b01000,
    S_APPEND = 5'b10000
  } pswl_state_e;

endpackage

[rtl/core/per_sender_event_window_ledger.sv]
// Top level of the per-sender event window ledger.
//
//  Channel   Dir   Handshake          Payload
//  in        in    in_valid/in_ready   pswl_in_t  (observe or query)
//  out       out   out_valid/out_ready pswl_out_t (one per query)
//  cfg       in    APB psel/penable    window_ms @0x0, retry_dedup_ms @0x4
//
// An item walks its sender's event list in the back end, reading one stored event
// at a time; an observe that appends adds an append step, and one that overflows
// a full list first shifts the list down for the eviction. The single read port of
// the event memory sets this pace.
// Reset clears all list lengths at once through per-sender valid bits.
// A two-beat queue keeps input accepted while the back end or the output stalls, until it fills.
module per_sender_event_window_ledger (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pswl_pkg::pswl_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pswl_pkg::pswl_out_t out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [31:0]         window_q, window_d, retry_q, retry_d;
  logic                q_valid, q_pop, wr_en;
  pswl_pkg::pswl_cmd_t q_item;

  // Register writes
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    window_d = window_q;
    retry_d  = retry_q;
    if (wr_en) begin
      unique case (paddr[2])
        pswl_pkg::REG_WINDOW: window_d = pwdata;
        pswl_pkg::REG_RETRY:  retry_d  = pwdata;
        default:              window_d = window_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= pswl_pkg::WINDOW_RESET;
      retry_q  <= pswl_pkg::RETRY_RESET;
    end else begin
      window_q <= window_d;
      retry_q  <= retry_d;
    end
  end

  assign prdata = (paddr[2] == pswl_pkg::REG_RETRY) ? retry_q : window_q;

  pswl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .window_i   (window_q),
    .retry_i    (retry_q),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  pswl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[rtl/core/pswl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pswl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/pswl_front.sv]
// Front end: accept items, work out window bounds, queue them for the back end.
module pswl_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pswl_pkg::pswl_in_t  in_data_i,
  input  logic [31:0]         window_i,
  input  logic [31:0]         retry_i,
  output logic                q_valid_o,
  output pswl_pkg::pswl_cmd_t q_item_o,
  input  logic                q_pop_i
);

  pswl_pkg::pswl_cmd_t                 cls;
  pswl_pkg::pswl_cmd_t                 mem_q [pswl_pkg::QUEUE_DEPTH];
  logic [pswl_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [pswl_pkg::QUEUE_PTR_W:0]      fill_q, fill_d;
  logic                                push, pop;

  // Classify the incoming beat
  always_comb begin
    cls.command      = in_data_i.command;
    cls.out_of_range = ({1'b0, in_data_i.sender} >= 9'(pswl_pkg::NUM_SENDERS));
    cls.now          = in_data_i.timestamp_ms;
    cls.cutoff       = (in_data_i.timestamp_ms >= {16'd0, window_i}) ?
                       in_data_i.timestamp_ms - {16'd0, window_i} : 48'd0;
    cls.retry_lo     = (in_data_i.timestamp_ms >= {16'd0, retry_i}) ?
                       ({1'b0, in_data_i.timestamp_ms} - {17'd0, retry_i} + 49'd1) : 49'd0;
    cls.sender       = in_data_i.sender;
    cls.kind         = in_data_i.kind;
    cls.dedup_key    = in_data_i.dedup_key;
    cls.airtime      = in_data_i.airtime;
  end

  assign in_ready_o = (fill_q != (pswl_pkg::QUEUE_PTR_W + 1)'(pswl_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    fill_d   = fill_q + (pswl_pkg::QUEUE_PTR_W + 1)'(push) - (pswl_pkg::QUEUE_PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

[rtl/core/pswl_back.sv]
// Back end: walk one sender's event list in memory to update it or report on it.
`include "assert_macros.svh"
module pswl_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pswl_pkg::pswl_cmd_t q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pswl_pkg::pswl_out_t out_data_o
);

  localparam logic [pswl_pkg::CNT_W-1:0] EPS_C = pswl_pkg::CNT_W'(pswl_pkg::EVENTS_PER_SENDER);

  pswl_pkg::pswl_state_e             state_q, state_d;
  pswl_pkg::pswl_cmd_t               item_q, item_d;
  logic [pswl_pkg::CNT_W-1:0]        n_q, n_d, rd_idx_q, rd_idx_d, w_q, w_d;
  logic [pswl_pkg::SLOT_W-1:0]       proc_idx_q, proc_idx_d;
  logic                              pend_q, pend_d, hit_q, hit_d;
  logic [15:0]                       req_seen_q, req_seen_d;
  logic [255:0]                      clr_seen_q, clr_seen_d;
  logic [4:0]                        req_q, req_d, clr_q, clr_d;
  logic [19:0]                       air_q, air_d;
  pswl_pkg::pswl_out_t               out_q, out_d;
  logic                              out_valid_q, out_valid_d;
  logic [pswl_pkg::NUM_SENDERS-1:0]  cnt_vld_q, cnt_vld_d;

  logic                              ev_we;
  logic [pswl_pkg::EV_AW-1:0]        ev_waddr, ev_raddr;
  pswl_pkg::pswl_ev_t                ev_wdata, ev_rdata;
  logic [pswl_pkg::EV_W-1:0]         ev_rraw;
  logic                              cnt_we;
  logic [pswl_pkg::SENDER_W-1:0]     cnt_waddr, cnt_raddr, cur_s;
  logic [pswl_pkg::CNT_W-1:0]        cnt_wdata, cnt_rdata;
  logic                              keep, match, issue, scan_done;
  logic [3:0]                        rkey;

  pswl_ram #(.WIDTH(pswl_pkg::EV_W), .DEPTH(pswl_pkg::EV_DEPTH)) u_ev_ram (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (ev_waddr),
    .wdata_i (ev_wdata),
    .raddr_i (ev_raddr),
    .rdata_o (ev_rraw)
  );

  pswl_ram #(.WIDTH(pswl_pkg::CNT_W), .DEPTH(pswl_pkg::NUM_SENDERS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign ev_rdata    = pswl_pkg::pswl_ev_t'(ev_rraw);
  assign cur_s       = item_q.sender[pswl_pkg::SENDER_W-1:0];
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Classify the event read back in the previous cycle
  always_comb begin
    keep  = (ev_rdata.time_ms >= item_q.cutoff);
    match = !hit_q && (ev_rdata.kind == item_q.kind) && (ev_rdata.key == item_q.dedup_key) &&
            (ev_rdata.time_ms <= item_q.now) && ({1'b0, ev_rdata.time_ms} >= item_q.retry_lo);
    rkey  = ev_rdata.key[3:0] & pswl_pkg::KEY4_MASK;
  end

  // Sequence one item through the event list
  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    w_d         = w_q;
    proc_idx_d  = proc_idx_q;
    pend_d      = 1'b0;
    hit_d       = hit_q;
    req_seen_d  = req_seen_q;
    clr_seen_d  = clr_seen_q;
    req_d       = req_q;
    clr_d       = clr_q;
    air_d       = air_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cnt_vld_d   = cnt_vld_q;
    q_pop_o     = 1'b0;
    ev_we       = 1'b0;
    ev_waddr    = {cur_s, w_q[pswl_pkg::SLOT_W-1:0]};
    ev_wdata    = ev_rdata;
    ev_raddr    = {cur_s, rd_idx_q[pswl_pkg::SLOT_W-1:0]};
    cnt_we      = 1'b0;
    cnt_waddr   = cur_s;
    cnt_wdata   = w_q;
    cnt_raddr   = q_item_i.sender[pswl_pkg::SENDER_W-1:0];
    issue       = 1'b0;
    scan_done   = 1'b0;

    unique case (state_q)
      pswl_pkg::S_IDLE: begin
        if (q_valid_i && (q_item_i.command == pswl_pkg::CMD_OBSERVE || !out_valid_d)) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          if (q_item_i.out_of_range) begin
            // Drop an observe, answer a query with zeros
            if (q_item_i.command == pswl_pkg::CMD_QUERY) begin
              out_d       = '0;
              out_valid_d = 1'b1;
            end
          end else begin
            state_d = pswl_pkg::S_CNT;
          end
        end
      end

      pswl_pkg::S_CNT: begin
        n_d        = cnt_vld_q[cur_s] ? cnt_rdata : '0;
        rd_idx_d   = '0;
        w_d        = '0;
        hit_d      = 1'b0;
        req_seen_d = '0;
        clr_seen_d = '0;
        req_d      = '0;
        clr_d      = '0;
        air_d      = '0;
        state_d    = pswl_pkg::S_SCAN;
      end

      pswl_pkg::S_SCAN: begin
        issue = (rd_idx_q < n_q);
        if (issue) begin
          rd_idx_d   = rd_idx_q + 1'b1;
          proc_idx_d = rd_idx_q[pswl_pkg::SLOT_W-1:0];
          pend_d     = 1'b1;
        end
        // Compact survivors forward, or tally them for a query
        if (pend_q && keep) begin
          if (item_q.command == pswl_pkg::CMD_OBSERVE) begin
            ev_we    = 1'b1;
            ev_wdata = ev_rdata;
            if (match) begin
              ev_wdata.time_ms = item_q.now;
              hit_d            = 1'b1;
            end
            w_d = w_q + 1'b1;
          end else begin
            air_d = air_q + {4'd0, ev_rdata.air};
            if (ev_rdata.kind == pswl_pkg::KIND_REQ && !req_seen_q[rkey]) begin
              req_seen_d[rkey] = 1'b1;
              req_d            = req_q + 5'd1;
            end else if (ev_rdata.kind == pswl_pkg::KIND_CLR && !clr_seen_q[ev_rdata.key]) begin
              clr_seen_d[ev_rdata.key] = 1'b1;
              clr_d                    = clr_q + 5'd1;
            end
          end
        end
        scan_done = !issue && !pend_q;
        if (scan_done) begin
          if (item_q.command == pswl_pkg::CMD_QUERY) begin
            out_d.apparent_count = (req_q > clr_q) ? req_q - clr_q : 5'd0;
            out_d.total_airtime  = air_q;
            out_d.request_count  = req_q;
            out_d.clear_count    = clr_q;
            out_valid_d          = 1'b1;
            state_d              = pswl_pkg::S_IDLE;
          end else if (hit_q) begin
            cnt_we    = 1'b1;
            cnt_wdata = w_q;
            state_d   = pswl_pkg::S_IDLE;
          end else if (w_q == EPS_C) begin
            rd_idx_d = pswl_pkg::CNT_W'(1);
            state_d  = pswl_pkg::S_EVICT;
          end else begin
            state_d = pswl_pkg::S_APPEND;
          end
        end
      end

      pswl_pkg::S_EVICT: begin
        // Shift the full list down by one slot to drop the oldest
        issue = (rd_idx_q < EPS_C);
        if (issue) begin
          rd_idx_d   = rd_idx_q + 1'b1;
          proc_idx_d = rd_idx_q[pswl_pkg::SLOT_W-1:0];
          pend_d     = 1'b1;
        end
        if (pend_q) begin
          ev_we    = 1'b1;
          ev_waddr = {cur_s, proc_idx_q - 1'b1};
          ev_wdata = ev_rdata;
        end
        if (!issue && !pend_q) begin
          w_d     = EPS_C - 1'b1;
          state_d = pswl_pkg::S_APPEND;
        end
      end

      pswl_pkg::S_APPEND: begin
        ev_we            = 1'b1;
        ev_wdata.time_ms = item_q.now;
        ev_wdata.kind    = item_q.kind;
        ev_wdata.key     = item_q.dedup_key;
        ev_wdata.air     = item_q.airtime;
        cnt_we           = 1'b1;
        cnt_wdata        = w_q + 1'b1;
        state_d          = pswl_pkg::S_IDLE;
      end

      default: begin
        state_d = pswl_pkg::S_IDLE;
      end
    endcase

    if (cnt_we) begin
      cnt_vld_d[cur_s] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pswl_pkg::S_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      cnt_vld_q   <= cnt_vld_d;
    end
  end

  // Working registers and result
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    n_q        <= n_d;
    rd_idx_q   <= rd_idx_d;
    w_q        <= w_d;
    proc_idx_q <= proc_idx_d;
    hit_q      <= hit_d;
    req_seen_q <= req_seen_d;
    clr_seen_q <= clr_seen_d;
    req_q      <= req_d;
    clr_q      <= clr_d;
    air_q      <= air_d;
    out_q      <= out_d;
  end

  `PSWL_ASSERT(a_compact_behind, clk_i, rst_ni, (state_q == pswl_pkg::S_SCAN && pend_q) |-> ({1'b0, w_q} <= {1'b0, proc_idx_q}), "write slot overtook read slot")
  `PSWL_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_we |-> (cnt_wdata <= EPS_C), "list length beyond capacity")
  `PSWL_NEVER(a_scan_write, clk_i, rst_ni, (state_q == pswl_pkg::S_SCAN) && ev_we && !pend_q, "event write without read data")
  `PSWL_ASSERT(a_query_room, clk_i, rst_ni, (q_pop_o && q_item_i.command == pswl_pkg::CMD_QUERY) |-> (!out_valid_q || out_ready_i), "query taken while result slot busy")

endmodule

[sim/per_sender_event_window_ledger_checker.sv]
// Scoreboard for the per-sender event window ledger: watches the channels, predicts and compares.
`timescale 1ns / 100ps
module per_sender_event_window_ledger_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  pswl_pkg::pswl_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  pswl_pkg::pswl_out_t out_data_i,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  input  logic                pready,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  query_count_o
);
  import pswl_pkg::*;

  typedef struct packed {
    logic [47:0] t;
    logic [7:0]  kind;
    logic [7:0]  key;
    logic [15:0] air;
  } ledger_ev_t;

  logic [31:0] window_q;
  logic [31:0] retry_q;
  int          list_len [NUM_SENDERS];
  ledger_ev_t  ledger [NUM_SENDERS][EVENTS_PER_SENDER];
  pswl_out_t   expected_metrics [$];

  assign pending_o = expected_metrics.size();

  // Print one mismatch line and count it
  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  function automatic logic [47:0] cutoff_at(input logic [47:0] now);
    return (now >= {16'd0, window_q}) ? now - {16'd0, window_q} : 48'd0;
  endfunction

  // Prune, refresh a retry, or append with eviction
  task automatic record_event(input pswl_in_t it);
    int s;
    int w;
    bit hit;
    logic [47:0] cut;
    ledger_ev_t e;
    s = it.sender;
    w = 0;
    hit = 0;
    cut = cutoff_at(it.timestamp_ms);
    for (int i = 0; i < list_len[s]; i++) begin
      e = ledger[s][i];
      if (e.t < cut) continue;
      if (!hit && e.kind == it.kind && e.key == it.dedup_key && e.t <= it.timestamp_ms &&
          (it.timestamp_ms - e.t) < {16'd0, retry_q}) begin
        e.t = it.timestamp_ms;
        hit = 1;
      end
      ledger[s][w] = e;
      w++;
    end
    if (!hit) begin
      if (w >= EVENTS_PER_SENDER) begin
        for (int i = 1; i < EVENTS_PER_SENDER; i++) ledger[s][i-1] = ledger[s][i];
        w = EVENTS_PER_SENDER - 1;
      end
      ledger[s][w] = '{it.timestamp_ms, it.kind, it.dedup_key, it.airtime};
      w++;
    end
    list_len[s] = w;
  endtask

  // Count distinct keys and sum airtime over in-window events
  function automatic pswl_out_t sender_metrics(input pswl_in_t it);
    pswl_out_t r;
    logic [15:0]  req_seen;
    logic [255:0] clr_seen;
    logic [19:0]  air;
    int req;
    int clr;
    logic [47:0] cut;
    ledger_ev_t e;
    req_seen = '0;
    clr_seen = '0;
    air = '0;
    req = 0;
    clr = 0;
    cut = cutoff_at(it.timestamp_ms);
    for (int i = 0; i < list_len[it.sender]; i++) begin
      e = ledger[it.sender][i];
      if (e.t < cut) continue;
      air += e.air;
      if (e.kind == KIND_REQ) begin
        if (!req_seen[e.key & KEY4_MASK]) begin
          req_seen[e.key & KEY4_MASK] = 1'b1;
          req++;
        end
      end else if (e.kind == KIND_CLR) begin
        if (!clr_seen[e.key]) begin
          clr_seen[e.key] = 1'b1;
          clr++;
        end
      end
    end
    r.apparent_count = (req > clr) ? 5'(req - clr) : 5'd0;
    r.total_airtime  = air;
    r.request_count  = 5'(req);
    r.clear_count    = 5'(clr);
    return r;
  endfunction

  // Follow register writes, accepted beats and results
  always @(posedge clk_i or negedge rst_ni) begin
    pswl_out_t want;
    if (!rst_ni) begin
      window_q = WINDOW_RESET;
      retry_q  = RETRY_RESET;
      fail_count_o = 0;
      query_count_o = 0;
      expected_metrics.delete();
      for (int s = 0; s < NUM_SENDERS; s++) list_len[s] = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {REG_WINDOW, 2'b00}) window_q = pwdata;
        else if (paddr == {REG_RETRY, 2'b00}) retry_q = pwdata;
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_metrics.size() == 0) begin
          report("unexpected result beat", 0, 0);
        end else begin
          want = expected_metrics.pop_front();
          if (out_data_i.apparent_count != want.apparent_count)
            report("apparent_count", out_data_i.apparent_count, want.apparent_count);
          if (out_data_i.total_airtime != want.total_airtime)
            report("total_airtime", out_data_i.total_airtime, want.total_airtime);
          if (out_data_i.request_count != want.request_count)
            report("request_count", out_data_i.request_count, want.request_count);
          if (out_data_i.clear_count != want.clear_count)
            report("clear_count", out_data_i.clear_count, want.clear_count);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.command == CMD_QUERY) begin
          expected_metrics.push_back(sender_metrics(in_data_i));
          query_count_o++;
        end else begin
          record_event(in_data_i);
        end
      end
    end
  end
endmodule

[sim/per_sender_event_window_ledger_tb.sv]
// Stimulus and verdict for the per-sender event window ledger.
`timescale 1ns / 100ps
module per_sender_event_window_ledger_tb;
  import pswl_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  pswl_in_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  pswl_out_t   out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          query_count;
  longint      cycle_count;
  bit          long_hold;
  int          beat_count;
  logic [47:0] now_ms;

  per_sender_event_window_ledger u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  per_sender_event_window_ledger_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending), .query_count_o(query_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort on a hung run
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Receiver: random stall per beat, one long hold-off
  initial begin
    int gap;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (600) @(posedge clk_i);
        long_hold = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic reg_write(input logic idx, input logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one beat after a random gap and hold it until taken
  task automatic send_beat(input pswl_in_t it, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8));
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    beat_count++;
  endtask

  task automatic send_event(input logic cmd, input logic [47:0] ts, input logic [7:0] snd,
                            input logic [7:0] kind, input logic [7:0] key,
                            input logic [15:0] air, input bit no_gap);
    pswl_in_t it;
    it = '{cmd, ts, snd, kind, key, air};
    send_beat(it, no_gap);
  endtask

  // Drain results and let the back end settle before a register write
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // One random phase: bursts on a few hot senders, with mostly small time steps
  task automatic random_phase(input int n);
    logic [7:0] hot [4];
    pswl_in_t it;
    for (int h = 0; h < 4; h++) hot[h] = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      it = '0;
      it.command = ($urandom_range(0, 3) == 0) ? CMD_QUERY : CMD_OBSERVE;
      case ($urandom_range(0, 9))
        0: now_ms += {$urandom, $urandom};
        1: it.timestamp_ms = now_ms - $urandom_range(0, 3000);
        default: now_ms += $urandom_range(0, 1500);
      endcase
      if ($urandom_range(0, 9) != 1) it.timestamp_ms = now_ms;
      it.sender = ($urandom_range(0, 7) == 0) ? 8'($urandom) : hot[$urandom_range(0, 3)];
      it.kind = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      it.dedup_key = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 5)) : 8'($urandom);
      it.airtime = 16'($urandom);
      send_beat(it, 0);
    end
  endtask

  initial begin
    logic [31:0] windows [5];
    logic [31:0] retries [5];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    long_hold = 0;
    beat_count = 0;
    now_ms = 48'd100000;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: retry refresh, fill and evict, clear keys, field extremes
    send_event(CMD_OBSERVE, 48'd0, 8'd0, KIND_REQ, 8'd0, 16'd0, 0);
    send_event(CMD_OBSERVE, 48'd10, 8'd0, KIND_REQ, 8'd0, 16'hffff, 0);
    send_event(CMD_OBSERVE, 48'd20, 8'd0, KIND_REQ, 8'h10, 16'd5, 0);
    send_event(CMD_OBSERVE, 48'd30, 8'd0, KIND_CLR, 8'hff, 16'd7, 0);
    send_event(CMD_OBSERVE, 48'd40, 8'd0, 8'hff, 8'd3, 16'd9, 0);
    send_event(CMD_QUERY, 48'd50, 8'd0, 8'd0, 8'd0, 16'd0, 0);
    for (int k = 0; k < 18; k++)
      send_event(CMD_OBSERVE, 48'd100 + k, 8'hff, KIND_REQ, 8'(k), 16'hffff, 0);
    send_event(CMD_QUERY, 48'd200, 8'hff, 8'd0, 8'd0, 16'd0, 0);
    send_event(CMD_QUERY, 48'hffff_ffff_ffff, 8'hff, 8'hff, 8'hff, 16'hffff, 0);
    send_event(CMD_OBSERVE, 48'hffff_ffff_ffff, 8'd0, KIND_CLR, 8'hff, 16'hffff, 0);
    send_event(CMD_OBSERVE, 48'd60, 8'd0, KIND_CLR, 8'hff, 16'd1, 0);
    send_event(CMD_QUERY, 48'hffff_ffff_ffff, 8'd0, 8'd0, 8'd0, 16'd0, 0);
    settle();

    // Register settings through the run, extremes included
    windows = '{32'd0, 32'hffff_ffff, 32'd5000, 32'd1, 32'd60000};
    retries = '{32'hffff_ffff, 32'd0, 32'd1500, 32'd1, 32'd2000};
    for (int p = 0; p < 5; p++) begin
      reg_write(REG_WINDOW, windows[p]);
      reg_write(REG_RETRY, retries[p]);
      if (p == 2) begin
        long_hold = 1;
        for (int k = 0; k < 30; k++)
          send_event(CMD_QUERY, now_ms, 8'd7, 8'd0, 8'd0, 16'd0, 1);
      end
      random_phase(RANDOM_ITEMS / 5);
      settle();
    end

    repeat (100) @(posedge clk_i);
    $display("covered %0d beats with %0d query results over five register settings",
             beat_count, query_count);
    $display("including a long output stall, full-list eviction and backwards timestamps");
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pswl_pkg.sv
rtl/core/pswl_ram.sv
rtl/core/pswl_front.sv
rtl/core/pswl_back.sv
rtl/core/per_sender_event_window_ledger.sv
sim/per_sender_event_window_ledger_checker.sv
sim/per_sender_event_window_ledger_tb.sv
